// ===== design/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
// the enclosing module provides clk and arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/bb_pkg.sv =====
package bb_pkg;

	localparam int DEFAULT_MAX_WIDTH = 1024;

	localparam int FRAME_WIDTH_BITS = 11;
	localparam logic [FRAME_WIDTH_BITS-1:0] RESET_FRAME_WIDTH = 11'd1024;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam int CHANNELS = 3;
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	typedef logic [CHANNELS-1:0][7:0] pixel_t;

	typedef enum logic {
		CMD_PIXEL,
		CMD_DRAIN
	} cmd_kind_t;

	// per-command control from the front to the back
	typedef struct packed {
		cmd_kind_t kind;
		logic      has_top;    // row above the middle row exists
		logic      has_left;   // pixel: middle result has left column; drain: left neighbor
		logic      has_right;  // drain: right neighbor inside the frame
		logic      emit_mid;   // pixel: result for the previous column
		logic      at_end;     // pixel: result for the last column; drain: last column
		logic      end_left;   // pixel: last-column result has a left column
	} cmd_flags_t;

	typedef struct packed {
		pixel_t px;
		logic   end_of_row;
		logic   end_of_frame;
		logic   last;
	} res_t;

	localparam int COLSUM_BITS = 10;  // up to three channel values
	localparam int SUM_BITS    = 12;  // up to nine channel values
	localparam int COUNT_BITS  = 4;   // neighbor count, 1 to 9
	localparam int NUM_BITS    = SUM_BITS + 1;
	localparam int RECIP_SHIFT = 17;
	localparam int RECIP_BITS  = 17;
	localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;

	localparam int CMDQ_DEPTH = 4;
	localparam int OUTQ_DEPTH = 4;

	// ceil(2^17 / (2n)); exact quotient for numerators below 2^13
	function automatic logic [RECIP_BITS-1:0] recip_of(input logic [COUNT_BITS-1:0] n);
		logic [RECIP_BITS-1:0] r;
		unique case (n)
			4'd1:    r = 17'd65536;
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd6:    r = 17'd10923;
			4'd9:    r = 17'd7282;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/bb_fifo.sv =====
`include "assert_macros.svh"

module bb_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = bb_pkg::CMDQ_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;

	assign full  = (cnt_q == CNTW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	`ASSERT_IMPLIES(a_no_overflow, push, !full, "push into a full queue")
	`ASSERT_IMPLIES(a_no_underflow, pop, !empty, "pop from an empty queue")

endmodule

// ===== design/bb_front.sv =====
`include "assert_macros.svh"

module bb_front #(
	parameter int MAX_WIDTH = bb_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic                                 opcode,
	input  bb_pkg::pixel_t                       px,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bb_pkg::FRAME_WIDTH_BITS-1:0]  frame_width,
	input  logic                                 cmdq_full,
	output logic                                 cmd_push,
	output bb_pkg::cmd_flags_t                   cmd_flags,
	output logic [$clog2(MAX_WIDTH)-1:0]         cmd_col,
	output bb_pkg::pixel_t                       cmd_px
);

	import bb_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam logic [1:0] ROWS_FULL = 2'd2;

	logic [FRAME_WIDTH_BITS-1:0] frame_width_q;
	logic [CW-1:0] col_cnt_q, col_cnt_n;
	logic [CW-1:0] drain_pos_q, drain_pos_n;
	logic [CW-1:0] drain_p;
	logic [1:0]    rows_q, rows_n;
	logic          draining_q, draining_n;
	logic [WW-1:0] act_w;
	logic [WW-1:0] col_plus1;
	logic [WW-1:0] drain_plus1;
	logic          accept;
	logic          last_col;
	logic          drain_go;
	logic          has_top;
	logic          emit;

	assign cfg_ready = 1'b1;
	assign accept    = push && !cmdq_full;

	// zero acts as one, anything above the line store depth is clipped
	always_comb begin
		if (frame_width_q == '0) begin
			act_w = WW'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			act_w = WW'(MAX_WIDTH);
		end else begin
			act_w = WW'(frame_width_q);
		end
	end

	assign col_plus1   = WW'(col_cnt_q) + WW'(1);
	assign last_col    = (col_plus1 == act_w);
	assign drain_p     = draining_q ? drain_pos_q : '0;
	assign drain_plus1 = WW'(drain_p) + WW'(1);
	assign drain_go    = draining_q || ((col_cnt_q == '0) && (rows_q != '0));
	assign has_top     = (rows_q == ROWS_FULL);
	assign emit        = (rows_q != '0);

	always_comb begin
		cmd_push    = 1'b0;
		cmd_flags   = '0;
		cmd_col     = col_cnt_q;
		cmd_px      = px;
		col_cnt_n   = col_cnt_q;
		rows_n      = rows_q;
		draining_n  = draining_q;
		drain_pos_n = drain_pos_q;
		if (cfg_valid) begin
			col_cnt_n   = '0;
			rows_n      = '0;
			draining_n  = 1'b0;
			drain_pos_n = '0;
		end else if (accept) begin
			unique case (opcode)
				OP_DRAIN: begin
					if (drain_go) begin
						cmd_push            = 1'b1;
						cmd_col             = drain_p;
						cmd_flags.kind      = CMD_DRAIN;
						cmd_flags.has_top   = has_top;
						cmd_flags.has_left  = (drain_p != '0);
						cmd_flags.has_right = (drain_plus1 < act_w);
						cmd_flags.at_end    = (drain_plus1 == act_w);
						if (drain_plus1 == act_w) begin
							col_cnt_n   = '0;
							rows_n      = '0;
							draining_n  = 1'b0;
							drain_pos_n = '0;
						end else begin
							draining_n  = 1'b1;
							drain_pos_n = drain_p + CW'(1);
						end
					end else if (col_cnt_q != '0) begin
						// partial row: the frame is abandoned
						col_cnt_n = '0;
						rows_n    = '0;
					end
				end
				OP_PIXEL: begin
					if (!draining_q) begin
						cmd_push           = 1'b1;
						cmd_flags.kind     = CMD_PIXEL;
						cmd_flags.has_top  = has_top;
						cmd_flags.has_left = (col_cnt_q > CW'(1));
						cmd_flags.emit_mid = emit && (col_cnt_q != '0);
						cmd_flags.at_end   = emit && last_col;
						cmd_flags.end_left = (col_cnt_q != '0);
						if (last_col) begin
							col_cnt_n = '0;
							if (rows_q != ROWS_FULL) begin
								rows_n = rows_q + 2'd1;
							end
						end else begin
							col_cnt_n = col_cnt_q + CW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= RESET_FRAME_WIDTH;
			col_cnt_q     <= '0;
			rows_q        <= '0;
			draining_q    <= 1'b0;
			drain_pos_q   <= '0;
		end else begin
			if (cfg_valid) begin
				frame_width_q <= frame_width;
			end
			col_cnt_q   <= col_cnt_n;
			rows_q      <= rows_n;
			draining_q  <= draining_n;
			drain_pos_q <= drain_pos_n;
		end
	end

	`ASSERT_IMPLIES(a_drain_whole_rows, draining_q, (col_cnt_q == '0) && (rows_q != '0), "drain without complete rows")

endmodule

// ===== design/bb_back.sv =====
`include "assert_macros.svh"

module bb_back #(
	parameter int MAX_WIDTH = bb_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmdq_empty,
	output logic                          cmd_pop,
	input  bb_pkg::cmd_flags_t            cmd_flags,
	input  logic [$clog2(MAX_WIDTH)-1:0]  cmd_col,
	input  bb_pkg::pixel_t                cmd_px,
	input  logic                          outq_full,
	output logic                          res_push,
	output bb_pkg::res_t                  res
);

	import bb_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_COL,
		ST_SUM,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t     state_q;
	logic       end_phase_q;
	cmd_flags_t flags_q;
	logic [CW-1:0] col_q;
	logic [CW-1:0] addr_q;
	pixel_t     px_q;

	// line stores: older holds the row above newer
	pixel_t older_mem [MAX_WIDTH];
	pixel_t newer_mem [MAX_WIDTH];
	pixel_t rd_older_q;
	pixel_t rd_newer_q;

	// column sums of the three latest columns, index 2 is the newest
	logic [COLSUM_BITS-1:0] cs_q [3][CHANNELS];
	logic [SUM_BITS-1:0]    sum_q [CHANNELS];
	logic [COUNT_BITS-1:0]  n_q;
	logic [PROD_BITS-1:0]   prod_q [CHANNELS];

	pixel_t                 top_px;
	logic [COLSUM_BITS-1:0] colsum_n [CHANNELS];
	logic [SUM_BITS-1:0]    dsum_n [CHANNELS];
	logic [SUM_BITS-1:0]    pick_sum [CHANNELS];
	logic [COUNT_BITS-1:0]  pick_n;
	logic [NUM_BITS-1:0]    num [CHANNELS];
	logic [RECIP_BITS-1:0]  rcp;
	logic [PROD_BITS-1:0]   prod_n [CHANNELS];
	logic [CW-1:0]          last_addr;
	logic                   drain_done;
	logic                   is_pixel;
	logic                   wr_en;

	assign is_pixel   = (flags_q.kind == CMD_PIXEL);
	assign cmd_pop    = (state_q == ST_IDLE) && !cmdq_empty;
	assign res_push   = (state_q == ST_OUT) && !outq_full;
	assign wr_en      = (state_q == ST_COL) && is_pixel;
	assign top_px     = flags_q.has_top ? rd_older_q : '0;
	assign last_addr  = col_q + CW'(flags_q.has_right);
	assign drain_done = (addr_q == last_addr);
	assign rcp        = recip_of(n_q);

	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			colsum_n[ch] = COLSUM_BITS'(top_px[ch]) + COLSUM_BITS'(rd_newer_q[ch])
				+ COLSUM_BITS'(px_q[ch]);
			dsum_n[ch] = sum_q[ch] + SUM_BITS'(top_px[ch]) + SUM_BITS'(rd_newer_q[ch]);
			if (!end_phase_q) begin
				pick_sum[ch] = (flags_q.has_left ? SUM_BITS'(cs_q[0][ch]) : '0)
					+ SUM_BITS'(cs_q[1][ch]) + SUM_BITS'(cs_q[2][ch]);
			end else begin
				pick_sum[ch] = (flags_q.end_left ? SUM_BITS'(cs_q[1][ch]) : '0)
					+ SUM_BITS'(cs_q[2][ch]);
			end
			// round half up: (2*sum + n) / (2*n)
			num[ch]    = {sum_q[ch], 1'b0} + NUM_BITS'(n_q);
			prod_n[ch] = PROD_BITS'(num[ch]) * PROD_BITS'(rcp);
		end
	end

	// rows times columns of the neighborhood
	always_comb begin
		if (!end_phase_q) begin
			if (flags_q.has_left) begin
				pick_n = flags_q.has_top ? COUNT_BITS'(9) : COUNT_BITS'(6);
			end else begin
				pick_n = flags_q.has_top ? COUNT_BITS'(6) : COUNT_BITS'(4);
			end
		end else begin
			if (flags_q.end_left) begin
				pick_n = flags_q.has_top ? COUNT_BITS'(6) : COUNT_BITS'(4);
			end else begin
				pick_n = flags_q.has_top ? COUNT_BITS'(3) : COUNT_BITS'(2);
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			res.px[ch] = prod_q[ch][RECIP_SHIFT +: 8];
		end
		if (is_pixel) begin
			res.end_of_row   = end_phase_q;
			res.end_of_frame = 1'b0;
			res.last         = end_phase_q || !flags_q.at_end;
		end else begin
			res.end_of_row   = flags_q.at_end;
			res.end_of_frame = flags_q.at_end;
			res.last         = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_older_q <= older_mem[addr_q];
			rd_newer_q <= newer_mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[col_q] <= rd_newer_q;
			newer_mem[col_q] <= px_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_pop) begin
					flags_q <= cmd_flags;
					col_q   <= cmd_col;
					px_q    <= cmd_px;
					// a drain walks from its left neighbor to its right neighbor
					if ((cmd_flags.kind == CMD_DRAIN) && cmd_flags.has_left) begin
						addr_q <= cmd_col - CW'(1);
					end else begin
						addr_q <= cmd_col;
					end
					for (int ch = 0; ch < CHANNELS; ch++) begin
						sum_q[ch] <= '0;
					end
					n_q <= '0;
				end
			end
			ST_COL: begin
				if (is_pixel) begin
					for (int ch = 0; ch < CHANNELS; ch++) begin
						cs_q[0][ch] <= cs_q[1][ch];
						cs_q[1][ch] <= cs_q[2][ch];
						cs_q[2][ch] <= colsum_n[ch];
					end
				end else begin
					for (int ch = 0; ch < CHANNELS; ch++) begin
						sum_q[ch] <= dsum_n[ch];
					end
					n_q <= n_q + (flags_q.has_top ? COUNT_BITS'(2) : COUNT_BITS'(1));
					if (!drain_done) begin
						addr_q <= addr_q + CW'(1);
					end
				end
			end
			ST_SUM: begin
				for (int ch = 0; ch < CHANNELS; ch++) begin
					sum_q[ch] <= pick_sum[ch];
				end
				n_q <= pick_n;
			end
			ST_MUL: begin
				for (int ch = 0; ch < CHANNELS; ch++) begin
					prod_q[ch] <= prod_n[ch];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			end_phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					end_phase_q <= 1'b0;
					if (!cmdq_empty) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_COL;
				end
				ST_COL: begin
					if (is_pixel) begin
						if (flags_q.emit_mid) begin
							state_q <= ST_SUM;
						end else if (flags_q.at_end) begin
							end_phase_q <= 1'b1;
							state_q     <= ST_SUM;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (drain_done) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_SUM: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!outq_full) begin
						if (is_pixel && !end_phase_q && flags_q.at_end) begin
							end_phase_q <= 1'b1;
							state_q     <= ST_SUM;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPLIES(a_div_nonzero, state_q == ST_MUL, n_q != '0, "mean taken over no neighbors")
	`ASSERT_IMPLIES(a_sum_pixel_only, state_q == ST_SUM, is_pixel, "window sum on a drain command")
	`ASSERT_NEXT(a_row_end_follows, res_push && !res.last, state_q == ST_SUM, "second result missing")

endmodule

// ===== design/box_blur_3x3_edge_clipped.sv =====
// channel   direction  handshake              payload
// input     in         push / full            opcode, in_red, in_green, in_blue
// result    out        empty / pop            out_red, out_green, out_blue,
//                                             end_of_row, end_of_frame, last
// config    in         cfg_valid / cfg_ready  frame_width
//
// the front takes one transaction per cycle while its 4-entry command queue has room.
// the back sequencer handles one command at a time: a pixel is read and column-summed,
// each result summed, multiplied and output; a drain reads its neighbor columns, then
// multiplies and outputs; one read port per line store, one reciprocal multiplier per channel.
// reset clears control state and queues; line stores are not cleared, a row is
// always written before its values are used.
// with pop low, results wait in a 4-entry queue; then the back stops and full rises.
module box_blur_3x3_edge_clipped #(
	parameter int MAX_WIDTH = bb_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                opcode,
	input  logic [7:0]                          in_red,
	input  logic [7:0]                          in_green,
	input  logic [7:0]                          in_blue,
	output logic                                empty,
	input  logic                                pop,
	output logic [7:0]                          out_red,
	output logic [7:0]                          out_green,
	output logic [7:0]                          out_blue,
	output logic                                end_of_row,
	output logic                                end_of_frame,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bb_pkg::FRAME_WIDTH_BITS-1:0] frame_width
);

	import bb_pkg::*;

	localparam int CW       = $clog2(MAX_WIDTH);
	localparam int CMD_BITS = $bits(cmd_flags_t) + CW + $bits(pixel_t);
	localparam int RES_BITS = $bits(res_t);

	pixel_t        in_px;
	logic          cmd_push;
	cmd_flags_t    cmd_flags;
	logic [CW-1:0] cmd_col;
	pixel_t        cmd_px;
	logic          cmdq_full;
	logic          cmdq_empty;
	logic          cmd_pop;
	logic [CMD_BITS-1:0] cmdq_rdata;
	cmd_flags_t    hd_flags;
	logic [CW-1:0] hd_col;
	pixel_t        hd_px;
	logic          res_push;
	logic          outq_full;
	logic          outq_pop;
	res_t          res_in;
	res_t          res_out;

	assign in_px[CH_RED]   = in_red;
	assign in_px[CH_GREEN] = in_green;
	assign in_px[CH_BLUE]  = in_blue;
	assign full            = cmdq_full;

	bb_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.opcode     (opcode),
		.px         (in_px),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.frame_width(frame_width),
		.cmdq_full  (cmdq_full),
		.cmd_push   (cmd_push),
		.cmd_flags  (cmd_flags),
		.cmd_col    (cmd_col),
		.cmd_px     (cmd_px)
	);

	bb_fifo #(
		.WIDTH(CMD_BITS),
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata ({cmd_flags, cmd_col, cmd_px}),
		.full  (cmdq_full),
		.pop   (cmd_pop),
		.rdata (cmdq_rdata),
		.empty (cmdq_empty)
	);

	assign {hd_flags, hd_col, hd_px} = cmdq_rdata;

	bb_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmdq_empty(cmdq_empty),
		.cmd_pop   (cmd_pop),
		.cmd_flags (hd_flags),
		.cmd_col   (hd_col),
		.cmd_px    (hd_px),
		.outq_full (outq_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	assign outq_pop = pop && !empty;

	bb_fifo #(
		.WIDTH(RES_BITS),
		.DEPTH(OUTQ_DEPTH)
	) u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (outq_full),
		.pop   (outq_pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign out_red      = res_out.px[CH_RED];
	assign out_green    = res_out.px[CH_GREEN];
	assign out_blue     = res_out.px[CH_BLUE];
	assign end_of_row   = res_out.end_of_row;
	assign end_of_frame = res_out.end_of_frame;
	assign last         = res_out.last;

endmodule
